/* rtl/pncq_pkg.sv */
package pncq_pkg;

	localparam int unsigned NumEntries = 5;
	localparam int unsigned ChanW      = 8;
	localparam int unsigned NumChan    = 4;
	localparam int unsigned ColorW     = ChanW * NumChan;
	localparam int unsigned DistW      = 18;
	localparam int unsigned IdxW       = 3;
	localparam int unsigned CfgIdxW    = 3;

	localparam logic [CfgIdxW-1:0] RegMode = CfgIdxW'(NumEntries);

	localparam logic [NumEntries-1:0][ColorW-1:0] PaletteReset = {
		32'h001F08FF,
		32'h044C1AFF,
		32'h1E7F23FF,
		32'h46B421FF,
		32'h79EB00FF
	};

	localparam logic ModeReset = 1'b1;

	// px[0] red, px[1] green, px[2] blue, px[3] alpha
	typedef logic [NumChan-1:0][ChanW-1:0] pixel_t;

	typedef struct packed {
		logic              valid;
		logic              take;
		pixel_t            px;
		logic [DistW-1:0]  score;
		logic [IdxW-1:0]   idx;
		logic [ColorW-1:0] color;
	} token_t;

	typedef struct packed {
		logic               wr;
		logic [CfgIdxW-1:0] index;
		logic [ColorW-1:0]  data;
	} cfg_wr_t;

endpackage

/* rtl/palette_nearest_color_quantizer_top.sv */
// Channel   Direction  Signals                                         Transfer when
// pixel     in         start, busy, pixel_red/green/blue/alpha         start && !busy
// result    out        done, out_red/green/blue/alpha, replaced,       done
//                      chosen_entry
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data       cfg_valid && cfg_ready
//
// One pixel per cycle; busy is always low. A pixel passes the premultiply registers s1
// and s2, the s1 and s2 registers of each of the five palette cells, then the output register.
// Reset loads the default palette and Manhattan mode; no clearing pass.
// The receiver cannot stall: each result is presented for one cycle with done.
module palette_nearest_color_quantizer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [7:0]                    pixel_red,
	input  logic [7:0]                    pixel_green,
	input  logic [7:0]                    pixel_blue,
	input  logic [7:0]                    pixel_alpha,
	output logic                          done,
	output logic [7:0]                    out_red,
	output logic [7:0]                    out_green,
	output logic [7:0]                    out_blue,
	output logic [7:0]                    out_alpha,
	output logic                          replaced,
	output logic [2:0]                    chosen_entry,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pncq_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [pncq_pkg::ColorW-1:0]   cfg_data
);

	logic                 mode_q;
	pncq_pkg::cfg_wr_t    cfg;
	pncq_pkg::pixel_t     px_in;
	pncq_pkg::token_t     tok [pncq_pkg::NumEntries+1];

	logic                 done_q;
	pncq_pkg::pixel_t     out_px_q;
	logic                 replaced_q;
	logic [2:0]           chosen_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_comb begin
		cfg.wr    = cfg_valid && cfg_ready;
		cfg.index = cfg_index;
		cfg.data  = cfg_data;
		px_in[0]  = pixel_red;
		px_in[1]  = pixel_green;
		px_in[2]  = pixel_blue;
		px_in[3]  = pixel_alpha;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pncq_pkg::ModeReset;
		end else if (cfg.wr && cfg.index == pncq_pkg::RegMode) begin
			mode_q <= cfg.data[0];
		end
	end

	pncq_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.mode   (mode_q),
		.in_valid (start && !busy),
		.px_in  (px_in),
		.tok_o  (tok[0])
	);

	for (genvar i = 0; i < pncq_pkg::NumEntries; i++) begin : g_cell
		pncq_cell #(
			.Idx        (pncq_pkg::IdxW'(i)),
			.ResetColor (pncq_pkg::PaletteReset[i])
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.mode   (mode_q),
			.cfg    (cfg),
			.tok_i  (tok[i]),
			.tok_o  (tok[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tok[pncq_pkg::NumEntries].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tok[pncq_pkg::NumEntries].take) begin
			for (int k = 0; k < 4; k++) begin
				out_px_q[k] <= tok[pncq_pkg::NumEntries].color[(3-k)*8 +: 8];
			end
			replaced_q <= 1'b1;
			chosen_q   <= tok[pncq_pkg::NumEntries].idx;
		end else begin
			out_px_q   <= tok[pncq_pkg::NumEntries].px;
			replaced_q <= 1'b0;
			chosen_q   <= '0;
		end
	end

	assign done         = done_q;
	assign out_red      = out_px_q[0];
	assign out_green    = out_px_q[1];
	assign out_blue     = out_px_q[2];
	assign out_alpha    = out_px_q[3];
	assign replaced     = replaced_q;
	assign chosen_entry = chosen_q;

endmodule

/* rtl/pncq_prep.sv */
module pncq_prep (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    mode,
	input  logic                    in_valid,
	input  pncq_pkg::pixel_t        px_in,
	output pncq_pkg::token_t        tok_o
);

	logic                    valid_s1;
	pncq_pkg::pixel_t        px_s1;
	logic [2:0][15:0]        prod_s1;

	logic                    valid_s2;
	pncq_pkg::token_t        tok_s2;

	pncq_pkg::pixel_t        px_pm;
	logic                    take;
	logic [16:0]             acc [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= px_in;
		for (int k = 0; k < 3; k++) begin
			prod_s1[k] <= {8'b0, px_in[k]} * {8'b0, px_in[3]};
		end
	end

	// floor(p/255) for p <= 255*255: (p + 1 + (p >> 8)) >> 8
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			acc[k] = {1'b0, prod_s1[k]} + 17'd1 + {9'b0, prod_s1[k][15:8]};
			px_pm[k] = mode ? acc[k][15:8] : px_s1[k];
		end
		px_pm[3] = px_s1[3];
		if (mode) begin
			take = px_s1[3] != 8'd0;
		end else begin
			take = (px_s1[0] != 8'd0) && (px_s1[1] != 8'd0) &&
				(px_s1[2] != 8'd0) && (px_s1[3] != 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		tok_s2.valid <= valid_s1;
		tok_s2.take  <= take;
		tok_s2.px    <= px_pm;
		tok_s2.score <= '0;
		tok_s2.idx   <= '0;
		tok_s2.color <= '0;
	end

	always_comb begin
		tok_o       = tok_s2;
		tok_o.valid = valid_s2;
	end

endmodule

/* rtl/pncq_cell.sv */
module pncq_cell #(
	parameter logic [pncq_pkg::IdxW-1:0]   Idx        = '0,
	parameter logic [pncq_pkg::ColorW-1:0] ResetColor = pncq_pkg::PaletteReset[0]
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 mode,
	input  pncq_pkg::cfg_wr_t    cfg,
	input  pncq_pkg::token_t     tok_i,
	output pncq_pkg::token_t     tok_o
);

	logic [pncq_pkg::ColorW-1:0] color_q;

	logic                        valid_s1;
	pncq_pkg::token_t            tok_s1;
	logic [3:0][15:0]            term_s1;

	logic                        valid_s2;
	pncq_pkg::token_t            tok_s2;

	logic [7:0]                  pal [4];
	logic [7:0]                  d [4];
	logic [15:0]                 term [4];
	logic [pncq_pkg::DistW-1:0]  cand_score;
	logic                        win;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= ResetColor;
		end else if (cfg.wr && cfg.index == pncq_pkg::CfgIdxW'(Idx)) begin
			color_q <= cfg.data;
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			pal[k]  = color_q[(3-k)*8 +: 8];
			d[k]    = (pal[k] > tok_i.px[k]) ? pal[k] - tok_i.px[k] : tok_i.px[k] - pal[k];
			term[k] = mode ? {8'b0, d[k]} : ({8'b0, d[k]} * {8'b0, d[k]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= tok_i.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		tok_s1 <= tok_i;
		for (int k = 0; k < 4; k++) begin
			term_s1[k] <= term[k];
		end
	end

	always_comb begin
		cand_score = pncq_pkg::DistW'(term_s1[0]) + pncq_pkg::DistW'(term_s1[1]) +
			pncq_pkg::DistW'(term_s1[2]) + pncq_pkg::DistW'(term_s1[3]);
		win = (Idx == '0) || (cand_score < tok_s1.score);
	end

	always_ff @(posedge clk) begin
		tok_s2 <= tok_s1;
		if (win) begin
			tok_s2.score <= cand_score;
			tok_s2.idx   <= Idx;
			tok_s2.color <= color_q;
		end
	end

	always_comb begin
		tok_o       = tok_s2;
		tok_o.valid = valid_s2;
	end

endmodule

/* tb/palette_nearest_color_quantizer_top_tb.sv */
module palette_nearest_color_quantizer_top_tb;

	typedef enum logic [pncq_pkg::CfgIdxW-1:0] {
		REG_PAL0, REG_PAL1, REG_PAL2, REG_PAL3, REG_PAL4, REG_MODE, REG_SPARE6, REG_SPARE7
	} cfg_reg_e;

	typedef enum logic {MODE_EUCLID, MODE_MANHATTAN} metric_e;

	typedef enum logic {ROW_PIX, ROW_CFG} row_kind_e;

	// color packed red, green, blue, alpha from msb down
	typedef struct packed {
		logic [31:0] color;
		logic        repl;
		logic [2:0]  entry;
	} quant_t;

	typedef struct packed {
		row_kind_e   kind;
		cfg_reg_e    reg_idx;
		logic [31:0] value;
		logic        typed;
		quant_t      want;
	} row_t;

	localparam int NumRows    = 34;
	localparam int NumPhases  = 8;
	localparam int PhaseItems = 250;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [7:0]  pixel_red = 8'd0;
	logic [7:0]  pixel_green = 8'd0;
	logic [7:0]  pixel_blue = 8'd0;
	logic [7:0]  pixel_alpha = 8'd0;
	logic        done;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic [7:0]  out_alpha;
	logic        replaced;
	logic [2:0]  chosen_entry;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [pncq_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [pncq_pkg::ColorW-1:0]  cfg_data = '0;

	logic [31:0] reset_pal [5] = '{32'h79EB00FF, 32'h46B421FF, 32'h1E7F23FF,
		32'h044C1AFF, 32'h001F08FF};
	logic [31:0] pal [5];
	metric_e     metric;
	quant_t      quant_due [$];
	int          mismatches = 0;

	row_t dir_rows [NumRows] = '{
		'{ROW_PIX, REG_PAL0,   32'h00000000, 1'b1, '{32'h00000000, 1'b0, 3'd0}},
		'{ROW_PIX, REG_PAL0,   32'hFFFFFF00, 1'b1, '{32'h00000000, 1'b0, 3'd0}},
		'{ROW_PIX, REG_PAL0,   32'h79EB00FF, 1'b1, '{32'h79EB00FF, 1'b1, 3'd0}},
		'{ROW_PIX, REG_PAL0,   32'h001F08FF, 1'b1, '{32'h001F08FF, 1'b1, 3'd4}},
		'{ROW_PIX, REG_PAL0,   32'hFFFFFFFF, 1'b0, '0},
		'{ROW_PIX, REG_PAL0,   32'hFFFFFF01, 1'b0, '0},
		'{ROW_PIX, REG_PAL0,   32'h8040C880, 1'b0, '0},
		// writes past the register list must not land
		'{ROW_CFG, REG_SPARE6, 32'hFFFFFFFF, 1'b0, '0},
		'{ROW_CFG, REG_SPARE7, 32'h00000000, 1'b0, '0},
		'{ROW_PIX, REG_PAL0,   32'h79EB00FF, 1'b1, '{32'h79EB00FF, 1'b1, 3'd0}},
		'{ROW_PIX, REG_PAL0,   32'h0A141E00, 1'b1, '{32'h00000000, 1'b0, 3'd0}},
		'{ROW_CFG, REG_MODE,   32'h00000000, 1'b0, '0},
		'{ROW_PIX, REG_PAL0,   32'h00FFFFFF, 1'b1, '{32'h00FFFFFF, 1'b0, 3'd0}},
		'{ROW_PIX, REG_PAL0,   32'hFF00FFFF, 1'b1, '{32'hFF00FFFF, 1'b0, 3'd0}},
		'{ROW_PIX, REG_PAL0,   32'hFFFF00FF, 1'b1, '{32'hFFFF00FF, 1'b0, 3'd0}},
		'{ROW_PIX, REG_PAL0,   32'hFFFFFF00, 1'b1, '{32'hFFFFFF00, 1'b0, 3'd0}},
		'{ROW_PIX, REG_PAL0,   32'h044C1AFF, 1'b1, '{32'h044C1AFF, 1'b1, 3'd3}},
		'{ROW_PIX, REG_PAL0,   32'hFFFFFFFF, 1'b0, '0},
		'{ROW_PIX, REG_PAL0,   32'h01010101, 1'b0, '0},
		// all entries equal: lowest index wins
		'{ROW_CFG, REG_PAL0,   32'h80808080, 1'b0, '0},
		'{ROW_CFG, REG_PAL1,   32'h80808080, 1'b0, '0},
		'{ROW_CFG, REG_PAL2,   32'h80808080, 1'b0, '0},
		'{ROW_CFG, REG_PAL3,   32'h80808080, 1'b0, '0},
		'{ROW_CFG, REG_PAL4,   32'h80808080, 1'b0, '0},
		'{ROW_PIX, REG_PAL0,   32'h01020304, 1'b1, '{32'h80808080, 1'b1, 3'd0}},
		'{ROW_CFG, REG_PAL0,   32'hFFFFFFFF, 1'b0, '0},
		'{ROW_CFG, REG_PAL1,   32'h00000000, 1'b0, '0},
		'{ROW_CFG, REG_PAL2,   32'h00000000, 1'b0, '0},
		'{ROW_CFG, REG_PAL3,   32'h00000000, 1'b0, '0},
		'{ROW_CFG, REG_PAL4,   32'h00000000, 1'b0, '0},
		'{ROW_PIX, REG_PAL0,   32'h01010101, 1'b1, '{32'h00000000, 1'b1, 3'd1}},
		'{ROW_CFG, REG_MODE,   32'h00000001, 1'b0, '0},
		'{ROW_PIX, REG_PAL0,   32'hFFFFFFFF, 1'b1, '{32'hFFFFFFFF, 1'b1, 3'd0}},
		'{ROW_PIX, REG_PAL0,   32'h7F7F7F80, 1'b0, '0}
	};

	palette_nearest_color_quantizer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.pixel_red    (pixel_red),
		.pixel_green  (pixel_green),
		.pixel_blue   (pixel_blue),
		.pixel_alpha  (pixel_alpha),
		.done         (done),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.out_alpha    (out_alpha),
		.replaced     (replaced),
		.chosen_entry (chosen_entry),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic quant_t nearest_color(logic [31:0] pix);
		int     px [4];
		int     d;
		int     score;
		int     best;
		int     best_idx;
		bit     take;
		quant_t q;
		for (int k = 0; k < 4; k++) px[k] = int'(pix[31-8*k -: 8]);
		if (metric == MODE_MANHATTAN) begin
			for (int k = 0; k < 3; k++) px[k] = px[k] * px[3] / 255;
			take = px[3] != 0;
		end else begin
			take = px[0] != 0 && px[1] != 0 && px[2] != 0 && px[3] != 0;
		end
		best = 0;
		best_idx = 0;
		if (take) begin
			for (int c = 0; c < 5; c++) begin
				score = 0;
				for (int k = 0; k < 4; k++) begin
					d = int'(pal[c][31-8*k -: 8]) - px[k];
					if (d < 0) d = -d;
					score += (metric == MODE_MANHATTAN) ? d : d * d;
				end
				if (c == 0 || score < best) begin
					best = score;
					best_idx = c;
				end
			end
			q.color = pal[best_idx];
			q.repl = 1'b1;
			q.entry = 3'(best_idx);
		end else begin
			q.color = {px[0][7:0], px[1][7:0], px[2][7:0], px[3][7:0]};
			q.repl = 1'b0;
			q.entry = 3'd0;
		end
		return q;
	endfunction

	function automatic logic [31:0] rand_pixel();
		logic [31:0] pix;
		logic [31:0] base;
		int          ch;
		pix = $urandom;
		case ($urandom_range(0, 9))
			4, 5, 6: begin
				// jitter around a palette entry to hit near-ties
				base = pal[$urandom_range(0, 4)];
				for (int k = 0; k < 4; k++) begin
					ch = int'(base[31-8*k -: 8]) + int'($urandom_range(0, 8)) - 4;
					if (ch < 0) ch = 0;
					if (ch > 255) ch = 255;
					pix[31-8*k -: 8] = ch[7:0];
				end
			end
			7: begin
				for (int k = 0; k < 4; k++)
					if ($urandom_range(0, 2) == 0) pix[31-8*k -: 8] = 8'h00;
			end
			8: begin
				case ($urandom_range(0, 2))
					0: pix[7:0] = 8'h00;
					1: pix[7:0] = 8'h01;
					default: pix[7:0] = 8'hFF;
				endcase
			end
			9: begin
				for (int k = 0; k < 4; k++)
					pix[31-8*k -: 8] = ($urandom_range(0, 1) ? 8'hFF : 8'h00) ^
						8'($urandom_range(0, 1));
			end
			default: ;
		endcase
		return pix;
	endfunction

	task automatic send_pixel(input logic [31:0] pix, input bit typed, input quant_t want);
		start <= 1'b1;
		pixel_red <= pix[31:24];
		pixel_green <= pix[23:16];
		pixel_blue <= pix[15:8];
		pixel_alpha <= pix[7:0];
		@(posedge clk);
		while (busy) @(posedge clk);
		quant_due.push_back(typed ? want : nearest_color(pix));
	endtask

	// leaves cfg_valid high so back-to-back writes stay in one burst
	task automatic write_reg(input cfg_reg_e idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx < REG_MODE) pal[idx] = data;
		else if (idx == REG_MODE) metric = metric_e'(data[0]);
	endtask

	task automatic idle(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (quant_due.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		quant_t want;
		if (arst_n && done) begin
			if (quant_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual %0h", $time,
					{out_red, out_green, out_blue, out_alpha});
			end else begin
				want = quant_due.pop_front();
				check_field("out_red", want.color[31:24], out_red);
				check_field("out_green", want.color[23:16], out_green);
				check_field("out_blue", want.color[15:8], out_blue);
				check_field("out_alpha", want.color[7:0], out_alpha);
				check_field("replaced", want.repl, replaced);
				check_field("chosen_entry", want.entry, chosen_entry);
			end
		end
	end

	initial begin
		bit          in_cfg;
		int          burst_left;
		int          gap;
		logic [31:0] new_pal [5];
		pal = reset_pal;
		metric = MODE_MANHATTAN;
		in_cfg = 1'b0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NumRows; i++) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				if (!in_cfg) begin
					drain();
					in_cfg = 1'b1;
				end
				write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
			end else begin
				if (in_cfg) begin
					cfg_valid <= 1'b0;
					in_cfg = 1'b0;
				end
				send_pixel(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		for (int phase = 0; phase < NumPhases; phase++) begin
			drain();
			for (int i = 0; i < 5; i++) begin
				case (phase % 4)
					0: new_pal[i] = reset_pal[i];
					1: new_pal[i] = $urandom;
					2: new_pal[i] = (i > 0 && $urandom_range(0, 1)) ?
						new_pal[$urandom_range(0, i - 1)] : $urandom;
					default: begin
						for (int k = 0; k < 4; k++)
							new_pal[i][31-8*k -: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					end
				endcase
				write_reg(cfg_reg_e'(i), new_pal[i]);
			end
			write_reg(REG_MODE, 32'((phase / 4 + phase) % 2));
			cfg_valid <= 1'b0;

			for (int n = 0; n < PhaseItems; n++) begin
				if (burst_left == 0) begin
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					if (gap != 0) idle(gap);
					burst_left = $urandom_range(1, 40);
				end
				if ($urandom_range(0, 199) == 0) drain();
				send_pixel(rand_pixel(), 1'b0, '0);
				burst_left--;
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && quant_due.size() == 0) begin
			$display("palette_nearest_color_quantizer_top_tb passed");
		end else begin
			$display("palette_nearest_color_quantizer_top_tb failed");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("palette_nearest_color_quantizer_top_tb failed");
		$finish;
	end

endmodule
